>>> rtl/tpsr_pkg.sv
// Shared types and constants of the two-pattern stream replacement block.
package tpsr_pkg;

    localparam int DATA_W     = 8;
    localparam int FIELD_W    = 64;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = 3;
    localparam int CFG_ADDR_W = 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_PATTERN       = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_PATTERN_LEN   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_REPLACE       = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_REPLACE_LEN   = 8'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_PATTERN      = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_PATTERN_LEN  = 8'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_REPLACE      = 8'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_REPLACE_LEN  = 8'd7;

    localparam logic [1:0] KIND_PASS = 2'd0;
    localparam logic [1:0] KIND_REP1 = 2'd1;
    localparam logic [1:0] KIND_REP2 = 2'd2;
    localparam logic [1:0] KIND_MARK = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] data;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] first_pattern;
        logic [LEN_W-1:0]   first_pattern_length;
        logic [FIELD_W-1:0] first_replacement;
        logic [LEN_W-1:0]   first_replacement_length;
        logic [FIELD_W-1:0] second_pattern;
        logic [LEN_W-1:0]   second_pattern_length;
        logic [FIELD_W-1:0] second_replacement;
        logic [LEN_W-1:0]   second_replacement_length;
    } cfg_t;

endpackage

>>> rtl/tpsr_front.sv
// Front end: lookahead window, pattern matching and command generation.
module tpsr_front #(
    parameter int PATTERN_MAX = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tpsr_pkg::DATA_W-1:0] s_tdata,
    input  logic                       s_tuser,
    input  logic                       s_tlast,
    input  tpsr_pkg::cfg_t             cfg,
    input  logic                       q_full,
    output tpsr_pkg::q_req_t           push_req
);
    import tpsr_pkg::*;

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_SHIFT  = 2'd2;
    localparam logic [1:0] ST_FINAL  = 2'd3;

    logic [DATA_W-1:0]      win_byte_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] win_srch_reg;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] skip_reg, skip_next;
    logic             flush_reg, flush_next;
    logic             pend_valid_reg, pend_valid_next;
    cmd_t             pend_reg, pend_next;

    logic             match1, match2, hit1, hit2, empty;
    logic [LEN_W-1:0] drop;
    cmd_t             dec_cmd, final_cmd;
    logic [CNT_W-1:0] count_dec;
    logic [1:0]       after_state;
    logic             wr_en, shift_en;

    always_comb begin
        match1 = (cfg.first_pattern_length != '0)
            && (cfg.first_pattern_length <= LEN_W'(PATTERN_MAX))
            && (cfg.first_pattern_length <= LEN_W'(count_reg));
        match2 = (cfg.second_pattern_length != '0)
            && (cfg.second_pattern_length <= LEN_W'(PATTERN_MAX))
            && (cfg.second_pattern_length <= LEN_W'(count_reg));
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if ((LEN_W'(k) < cfg.first_pattern_length)
                && (win_byte_reg[k] != cfg.first_pattern[DATA_W*k +: DATA_W])) begin
                match1 = 1'b0;
            end
            if ((LEN_W'(k) < cfg.second_pattern_length)
                && (win_byte_reg[k] != cfg.second_pattern[DATA_W*k +: DATA_W])) begin
                match2 = 1'b0;
            end
        end
    end

    always_comb begin
        hit2 = win_srch_reg[0] && match2;
        hit1 = win_srch_reg[0] && !match2 && match1;
        dec_cmd.data = win_byte_reg[0];
        dec_cmd.last = 1'b0;
        if (hit2) begin
            dec_cmd.kind = KIND_REP2;
            drop         = cfg.second_pattern_length;
            empty        = (cfg.second_replacement_length == '0);
        end else if (hit1) begin
            dec_cmd.kind = KIND_REP1;
            drop         = cfg.first_pattern_length;
            empty        = (cfg.first_replacement_length == '0);
        end else begin
            dec_cmd.kind = KIND_PASS;
            drop         = LEN_W'(1);
            empty        = 1'b0;
        end

        count_dec = count_reg - CNT_W'(1);
        if (!flush_reg) begin
            after_state = ST_ACCEPT;
        end else if (count_dec == '0) begin
            after_state = ST_FINAL;
        end else begin
            after_state = ST_DECIDE;
        end

        if (pend_valid_reg) begin
            final_cmd      = pend_reg;
            final_cmd.last = 1'b1;
        end else begin
            final_cmd.kind = KIND_MARK;
            final_cmd.data = '0;
            final_cmd.last = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        skip_next       = skip_reg;
        flush_next      = flush_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push_req.valid  = 1'b0;
        push_req.cmd    = dec_cmd;
        wr_en           = 1'b0;
        shift_en        = 1'b0;
        s_tready        = (state_reg == ST_ACCEPT);
        case (state_reg)
            ST_ACCEPT: begin
                if (s_tvalid) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    flush_next = s_tlast;
                    if (s_tlast || ((count_reg + CNT_W'(1)) == CNT_W'(PATTERN_MAX))) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (!q_full) begin
                    shift_en   = 1'b1;
                    count_next = count_dec;
                    skip_next  = drop - LEN_W'(1);
                    if (!empty) begin
                        if (flush_reg) begin
                            push_req.valid  = pend_valid_reg;
                            push_req.cmd    = pend_reg;
                            pend_next       = dec_cmd;
                            pend_valid_next = 1'b1;
                        end else begin
                            push_req.valid = 1'b1;
                        end
                    end
                    state_next = (drop != LEN_W'(1)) ? ST_SHIFT : after_state;
                end
            end
            ST_SHIFT: begin
                shift_en   = 1'b1;
                count_next = count_dec;
                skip_next  = skip_reg - LEN_W'(1);
                if (skip_reg == LEN_W'(1)) begin
                    state_next = after_state;
                end
            end
            ST_FINAL: begin
                if (!q_full) begin
                    push_req.valid  = 1'b1;
                    push_req.cmd    = final_cmd;
                    pend_valid_next = 1'b0;
                    flush_next      = 1'b0;
                    state_next      = ST_ACCEPT;
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_ACCEPT;
            count_reg      <= '0;
            skip_reg       <= '0;
            flush_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            skip_reg       <= skip_next;
            flush_reg      <= flush_next;
            pend_valid_reg <= pend_valid_next;
        end
        pend_reg <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                if (CNT_W'(k) == count_reg) begin
                    win_byte_reg[k] <= s_tdata;
                    win_srch_reg[k] <= s_tuser;
                end
            end
        end else if (shift_en) begin
            for (int k = 0; k < PATTERN_MAX - 1; k++) begin
                win_byte_reg[k] <= win_byte_reg[k+1];
                win_srch_reg[k] <= win_srch_reg[k+1];
            end
        end
    end

endmodule

>>> rtl/tpsr_queue.sv
// Short command queue between the front end and the output expander.
module tpsr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  tpsr_pkg::q_req_t push_req,
    output logic             full,
    output tpsr_pkg::q_req_t head,
    input  logic             pop
);
    import tpsr_pkg::*;

    cmd_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] fill_reg, fill_next;
    logic               do_push, do_pop;

    always_comb begin
        full        = (fill_reg == Q_CNT_W'(Q_DEPTH));
        head.valid  = (fill_reg != '0);
        head.cmd    = mem[rd_ptr_reg];
        do_push     = push_req.valid && !full;
        do_pop      = pop && head.valid;
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_req.cmd;
        end
    end

endmodule

>>> rtl/tpsr_back.sv
// Back end: expands queued commands into output bytes behind an output register.
module tpsr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tpsr_pkg::cfg_t              cfg,
    input  tpsr_pkg::q_req_t            head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tpsr_pkg::DATA_W-1:0] m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);
    import tpsr_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_byte_reg, out_byte_next;
    logic              out_has_reg, out_has_next;
    logic              out_last_reg, out_last_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic               load, rep_final;
    logic [FIELD_W-1:0] rep_bytes;
    logic [LEN_W-1:0]   rep_len;
    logic [DATA_W-1:0]  rep_byte;

    always_comb begin
        load      = !out_valid_reg || m_tready;
        rep_bytes = (head.cmd.kind == KIND_REP2) ? cfg.second_replacement
                                                 : cfg.first_replacement;
        rep_len   = (head.cmd.kind == KIND_REP2) ? cfg.second_replacement_length
                                                 : cfg.first_replacement_length;
        rep_byte  = rep_bytes[{idx_reg, 3'b000} +: DATA_W];
        rep_final = ((LEN_W'(idx_reg) + LEN_W'(1)) == rep_len);

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        if (load) begin
            out_valid_next = head.valid;
            if (head.valid) begin
                case (head.cmd.kind)
                    KIND_MARK: begin
                        out_byte_next = '0;
                        out_has_next  = 1'b0;
                        out_last_next = 1'b1;
                        pop           = 1'b1;
                    end
                    KIND_REP1, KIND_REP2: begin
                        out_byte_next = rep_byte;
                        out_has_next  = 1'b1;
                        out_last_next = head.cmd.last && rep_final;
                        if (rep_final) begin
                            pop      = 1'b1;
                            idx_next = '0;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    default: begin
                        out_byte_next = head.cmd.data;
                        out_has_next  = 1'b1;
                        out_last_next = head.cmd.last;
                        pop           = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
        out_byte_reg <= out_byte_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/two_pattern_stream_replace.sv
// Top level of the two-pattern streaming find-and-replace block.
// A byte is taken every cycle while the window fills; once it is full, or at the end of a string,
// each decision is made in a decide state that stalls on a full queue, with a shift state per
// further matched byte; a flush ends in a final state that pushes the held command as last, or a
// marker. Results pass the queue and the output register, then leave at one byte per cycle while
// m_tready is high. The synchronous active-low reset clears config, window count and queue.
module two_pattern_stream_replace #(
    parameter int PATTERN_MAX     = 8,
    parameter int REPLACEMENT_MAX = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tpsr_pkg::DATA_W-1:0]     s_tdata,   // data_byte
    input  logic                            s_tuser,   // searchable
    input  logic                            s_tlast,   // end_of_string
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tpsr_pkg::DATA_W-1:0]     m_tdata,   // out_byte
    output logic                            m_tuser,   // has_byte
    output logic                            m_tlast,   // last_of_string
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tpsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tpsr_pkg::FIELD_W-1:0]    cfg_data
);
    import tpsr_pkg::*;

    logic [FIELD_W-1:0] pat1_reg, rep1_reg, pat2_reg, rep2_reg;
    logic [LEN_W-1:0]   pat1_len_reg, rep1_len_reg, pat2_len_reg, rep2_len_reg;

    cfg_t   cfg;
    q_req_t push_req;
    q_req_t head;
    logic   q_full;
    logic   pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat1_reg     <= '0;
            pat1_len_reg <= '0;
            rep1_reg     <= '0;
            rep1_len_reg <= '0;
            pat2_reg     <= '0;
            pat2_len_reg <= '0;
            rep2_reg     <= '0;
            rep2_len_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_FIRST_PATTERN:      pat1_reg     <= cfg_data;
                REG_FIRST_PATTERN_LEN:  pat1_len_reg <= cfg_data[LEN_W-1:0];
                REG_FIRST_REPLACE:      rep1_reg     <= cfg_data;
                REG_FIRST_REPLACE_LEN:  rep1_len_reg <= cfg_data[LEN_W-1:0];
                REG_SECOND_PATTERN:     pat2_reg     <= cfg_data;
                REG_SECOND_PATTERN_LEN: pat2_len_reg <= cfg_data[LEN_W-1:0];
                REG_SECOND_REPLACE:     rep2_reg     <= cfg_data;
                REG_SECOND_REPLACE_LEN: rep2_len_reg <= cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Replacement lengths saturate at the longest supported replacement.
    always_comb begin
        cfg.first_pattern            = pat1_reg;
        cfg.first_pattern_length     = pat1_len_reg;
        cfg.first_replacement        = rep1_reg;
        cfg.first_replacement_length = (rep1_len_reg > LEN_W'(REPLACEMENT_MAX))
                                       ? LEN_W'(REPLACEMENT_MAX) : rep1_len_reg;
        cfg.second_pattern           = pat2_reg;
        cfg.second_pattern_length    = pat2_len_reg;
        cfg.second_replacement       = rep2_reg;
        cfg.second_replacement_length = (rep2_len_reg > LEN_W'(REPLACEMENT_MAX))
                                        ? LEN_W'(REPLACEMENT_MAX) : rep2_len_reg;
    end

    tpsr_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg      (cfg),
        .q_full   (q_full),
        .push_req (push_req)
    );

    tpsr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_req (push_req),
        .full     (q_full),
        .head     (head),
        .pop      (pop)
    );

    tpsr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
